>>> hw/rtl/pfc_pkg.sv
`timescale 1ns / 1ps

package pfc_pkg;

    localparam int GRID_SIDE = 5;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int LETTERS   = 26;

    localparam int LETTER_W = 5;
    localparam int COORD_W  = $clog2(GRID_SIDE);
    localparam int POS_W    = 2 * COORD_W;
    localparam int CELL_W   = $clog2(CELLS);
    localparam int FILL_W   = $clog2(CELLS + 1);
    localparam int WALK_W   = $clog2(LETTERS);

    localparam logic [LETTER_W-1:0] CODE_I = LETTER_W'(8);
    localparam logic [LETTER_W-1:0] CODE_J = LETTER_W'(9);
    localparam logic [LETTER_W-1:0] CODE_X = LETTER_W'(23);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_CIPHER_MODE = '0;

    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    typedef enum logic [1:0] {
        CMD_KEY      = 2'd0,
        CMD_END_KEY  = 2'd1,
        CMD_TEXT     = 2'd2,
        CMD_END_TEXT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PFC_IDLE,
        PFC_FILL,
        PFC_PAIR
    } state_t;

    typedef struct packed {
        cmd_t                command;
        logic [LETTER_W-1:0] letter;
    } in_word_t;

    typedef struct packed {
        logic [LETTER_W-1:0] first_letter;
        logic [LETTER_W-1:0] second_letter;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic fill_step;
        logic pair_load;
    } pfc_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic fill_start;
        logic pair_start;
        logic walk_last;
        logic out_free;
    } pfc_stat_t;

    function automatic logic [COORD_W-1:0] wrap_step(input logic [COORD_W-1:0] v,
                                                     input logic back);
        logic [COORD_W-1:0] r;
        if (back)
        begin
            r = (v == '0) ? COORD_W'(GRID_SIDE - 1) : v - COORD_W'(1);
        end
        else
        begin
            r = (v == COORD_W'(GRID_SIDE - 1)) ? '0 : v + COORD_W'(1);
        end
        return r;
    endfunction

    function automatic logic [CELL_W-1:0] cell_index(input logic [COORD_W-1:0] row,
                                                     input logic [COORD_W-1:0] col);
        return CELL_W'(row * GRID_SIDE + col);
    endfunction

endpackage

>>> hw/rtl/pfc_ctrl.sv
`timescale 1ns / 1ps

module pfc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pfc_pkg::pfc_stat_t stat,
    output pfc_pkg::pfc_ctl_t  ctl
);
    import pfc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PFC_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        ctl           = '0;
        in_ready      = 1'b0;
        case (state_reg)
            PFC_IDLE:
            begin
                in_ready   = 1'b1;
                ctl.accept = in_valid;
                if (in_valid && stat.fill_start)
                begin
                    state_next = PFC_FILL;
                end
                else if (in_valid && stat.pair_start)
                begin
                    state_next = PFC_PAIR;
                end
            end
            PFC_FILL:
            begin
                ctl.fill_step = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = PFC_IDLE;
                end
            end
            PFC_PAIR:
            begin
                if (stat.out_free)
                begin
                    ctl.pair_load = 1'b1;
                    state_next    = PFC_IDLE;
                end
            end
            default:
            begin
                state_next = PFC_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/pfc_datapath.sv
`timescale 1ns / 1ps

module pfc_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  pfc_pkg::in_word_t  in_data,
    input  logic               cipher_mode,
    input  pfc_pkg::pfc_ctl_t  ctl,
    output pfc_pkg::pfc_stat_t stat,
    output logic               out_valid,
    input  logic               out_ready,
    output pfc_pkg::out_word_t out_data
);
    import pfc_pkg::*;

    logic [LETTER_W-1:0] sq_mem  [CELLS];
    logic [POS_W-1:0]    pos_mem [LETTERS];

    logic [LETTERS-1:0]  used_reg,         used_next;
    logic [FILL_W-1:0]   fill_count_reg,   fill_count_next;
    logic [COORD_W-1:0]  fill_row_reg,     fill_row_next;
    logic [COORD_W-1:0]  fill_col_reg,     fill_col_next;
    logic                key_finished_reg, key_finished_next;
    logic [LETTER_W-1:0] held_letter_reg,  held_letter_next;
    logic                held_valid_reg,   held_valid_next;
    logic [WALK_W-1:0]   walk_reg,         walk_next;
    logic                out_valid_reg,    out_valid_next;
    logic [POS_W-1:0]    pos_a_reg;
    logic [POS_W-1:0]    pos_b_reg;
    out_word_t           out_data_reg;

    logic [LETTER_W-1:0] code;
    logic                code_ok;
    logic                key_restart;
    logic [LETTERS-1:0]  used_base;
    logic [FILL_W-1:0]   fill_base;
    logic [COORD_W-1:0]  row_base;
    logic [COORD_W-1:0]  col_base;
    logic                add_cand;
    logic [LETTER_W-1:0] add_code;
    logic                add_do;
    logic                doubled;
    logic [LETTER_W-1:0] second;
    logic [COORD_W-1:0]  ra, ca, rb, cb;
    logic [CELL_W-1:0]   cell_a, cell_b;

    assign code    = (in_data.letter == CODE_J) ? CODE_I : in_data.letter;
    assign code_ok = code < LETTER_W'(LETTERS);
    assign doubled = (in_data.command == CMD_TEXT) && (cipher_mode == MODE_ENCRYPT)
                     && (held_letter_reg == code);
    assign second  = ((in_data.command == CMD_TEXT) && !doubled) ? code : CODE_X;

    assign stat.fill_start = (in_data.command == CMD_END_KEY) && !key_finished_reg;
    assign stat.pair_start = key_finished_reg && held_valid_reg
                             && (((in_data.command == CMD_TEXT) && code_ok)
                                 || (in_data.command == CMD_END_TEXT));
    assign stat.walk_last  = walk_reg == WALK_W'(LETTERS - 1);
    assign stat.out_free   = !out_valid_reg || out_ready;

    // square insert: key letter or one step of the alphabet walk
    always_comb
    begin
        key_restart = ctl.accept && (in_data.command == CMD_KEY) && code_ok
                      && key_finished_reg;
        used_base   = key_restart ? '0 : used_reg;
        fill_base   = key_restart ? '0 : fill_count_reg;
        row_base    = key_restart ? '0 : fill_row_reg;
        col_base    = key_restart ? '0 : fill_col_reg;
        if (ctl.fill_step)
        begin
            add_code = walk_reg;
            add_cand = walk_reg != CODE_J;
        end
        else
        begin
            add_code = code;
            add_cand = ctl.accept && (in_data.command == CMD_KEY) && code_ok;
        end
        add_do = add_cand && !used_base[add_code] && (fill_base < FILL_W'(CELLS));
    end

    always_comb
    begin
        used_next         = used_base;
        fill_count_next   = fill_base;
        fill_row_next     = row_base;
        fill_col_next     = col_base;
        key_finished_next = key_restart ? 1'b0 : key_finished_reg;
        held_letter_next  = held_letter_reg;
        held_valid_next   = held_valid_reg;
        walk_next         = walk_reg;

        if (add_do)
        begin
            used_next       = used_base | (LETTERS'(1) << add_code);
            fill_count_next = fill_base + FILL_W'(1);
            if (col_base == COORD_W'(GRID_SIDE - 1))
            begin
                fill_col_next = '0;
                fill_row_next = row_base + COORD_W'(1);
            end
            else
            begin
                fill_col_next = col_base + COORD_W'(1);
            end
        end

        if (key_restart)
        begin
            held_letter_next = '0;
            held_valid_next  = 1'b0;
        end

        if (ctl.accept && stat.fill_start)
        begin
            walk_next        = '0;
            held_letter_next = '0;
            held_valid_next  = 1'b0;
        end

        if (ctl.fill_step)
        begin
            walk_next = walk_reg + WALK_W'(1);
            if (stat.walk_last)
            begin
                key_finished_next = 1'b1;
            end
        end

        if (ctl.accept && key_finished_reg)
        begin
            if ((in_data.command == CMD_TEXT) && code_ok)
            begin
                if (!held_valid_reg)
                begin
                    held_letter_next = code;
                    held_valid_next  = 1'b1;
                end
                else if (!doubled)
                begin
                    held_letter_next = '0;
                    held_valid_next  = 1'b0;
                end
            end
            else if (in_data.command == CMD_END_TEXT)
            begin
                held_letter_next = '0;
                held_valid_next  = 1'b0;
            end
        end
    end

    // pair transform on looked-up coordinates
    always_comb
    begin
        ra = pos_a_reg[POS_W-1:COORD_W];
        ca = pos_a_reg[COORD_W-1:0];
        rb = pos_b_reg[POS_W-1:COORD_W];
        cb = pos_b_reg[COORD_W-1:0];
        if (ra == rb)
        begin
            cell_a = cell_index(ra, wrap_step(ca, cipher_mode));
            cell_b = cell_index(rb, wrap_step(cb, cipher_mode));
        end
        else if (ca == cb)
        begin
            cell_a = cell_index(wrap_step(ra, cipher_mode), ca);
            cell_b = cell_index(wrap_step(rb, cipher_mode), cb);
        end
        else
        begin
            cell_a = cell_index(ra, cb);
            cell_b = cell_index(rb, ca);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.pair_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg         <= '0;
            fill_count_reg   <= '0;
            fill_row_reg     <= '0;
            fill_col_reg     <= '0;
            key_finished_reg <= 1'b0;
            held_letter_reg  <= '0;
            held_valid_reg   <= 1'b0;
            walk_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            used_reg         <= used_next;
            fill_count_reg   <= fill_count_next;
            fill_row_reg     <= fill_row_next;
            fill_col_reg     <= fill_col_next;
            key_finished_reg <= key_finished_next;
            held_letter_reg  <= held_letter_next;
            held_valid_reg   <= held_valid_next;
            walk_reg         <= walk_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // key square and letter position stores
    always_ff @(posedge clk)
    begin
        if (add_do)
        begin
            sq_mem[fill_base[CELL_W-1:0]] <= add_code;
            pos_mem[add_code]             <= {row_base, col_base};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept && stat.pair_start)
        begin
            pos_a_reg <= pos_mem[held_letter_reg];
            pos_b_reg <= pos_mem[second];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.pair_load)
        begin
            out_data_reg.first_letter  <= sq_mem[cell_a];
            out_data_reg.second_letter <= sq_mem[cell_b];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> hw/rtl/playfair_digraph_cipher_core.sv
`timescale 1ns / 1ps
// channel  | handshake                      | word
// ---------+--------------------------------+-------------------------------
// input    | in_valid / in_ready            | in_data: command, letter
// output   | out_valid / out_ready          | out_data: first/second_letter
// config   | psel, penable, pwrite / pready | cipher_mode at 0x0
//
// Key letters, held text letters and ignored words are taken without leaving idle.
// A text pair reads the position store, then reads the square into out_data.
// End of key starts the alphabet walk: it visits one letter per cycle, inserting unused ones.
// A pair waiting on a full output register stalls before the square read.
// rst_n clears control state; square and position stores are not cleared.

module playfair_digraph_cipher_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pfc_pkg::in_word_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pfc_pkg::out_word_t                  out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pfc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [pfc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [pfc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import pfc_pkg::*;

    logic      cipher_mode_reg, cipher_mode_next;
    logic      reg_sel;
    pfc_ctl_t  ctl;
    pfc_stat_t stat;

    assign pready  = 1'b1;
    assign reg_sel = paddr[APB_ADDR_W-1:2] == REG_CIPHER_MODE;

    always_comb
    begin
        cipher_mode_next = cipher_mode_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            cipher_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_mode_reg <= MODE_ENCRYPT;
        end
        else
        begin
            cipher_mode_reg <= cipher_mode_next;
        end
    end

    assign prdata = reg_sel ? {{(APB_DATA_W - 1){1'b0}}, cipher_mode_reg} : '0;

    pfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    pfc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_data     (in_data),
        .cipher_mode (cipher_mode_reg),
        .ctl         (ctl),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pair_load |-> (!out_valid || out_ready))
        else $error("pair loaded over an untaken result");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pair_load |=> out_valid)
        else $error("loaded pair not presented");

    a_pair_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && stat.pair_start) |=> !in_ready)
        else $error("input taken while a pair is in flight");

    a_fill_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && ctl.fill_step))
        else $error("input open during alphabet walk");

endmodule
